// File: rtl/core/xcfd_pkg.sv
// shared constants and codes for the checked frame deframer
package xcfd_pkg;

    localparam int RX_BYTE_W    = 8;
    localparam int KIND_W       = 2;
    localparam int CMD_W        = 8;
    localparam int LEN_W        = 16;
    localparam int PHASE_W      = 4;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = CMD_W + LEN_W + RX_BYTE_W;

    localparam logic [RX_BYTE_W-1:0] SYNC_A = 8'hAA;
    localparam logic [RX_BYTE_W-1:0] SYNC_B = 8'h55;

    localparam logic [PHASE_W-1:0] PH_HUNT_HI = 4'd0;
    localparam logic [PHASE_W-1:0] PH_HUNT_LO = 4'd1;
    localparam logic [PHASE_W-1:0] PH_CMD     = 4'd2;
    localparam logic [PHASE_W-1:0] PH_LEN_HI  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_LEN_LO  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 4'd5;
    localparam logic [PHASE_W-1:0] PH_CHECK   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_TAIL_HI = 4'd7;
    localparam logic [PHASE_W-1:0] PH_TAIL_LO = 4'd8;

    localparam logic [KIND_W-1:0] EV_PAYLOAD  = 2'd0;
    localparam logic [KIND_W-1:0] EV_GOOD     = 2'd1;
    localparam logic [KIND_W-1:0] EV_CHECKSUM = 2'd2;
    localparam logic [KIND_W-1:0] EV_TAIL     = 2'd3;

endpackage

// File: rtl/core/xor_checked_frame_deframer.sv
// byte-stream frame parser: header AA 55, command, length, payload, xor check, tail 55 AA
// an accepted byte waits in the input register until the result register is free, then its result is registered there
// throughput: one byte per cycle while the master side takes results; input register, parse logic, result register
// the result register frees the input stage as soon as the master side takes it
// reset (synchronous, i_rst_n low): hunting for header, frame state and xor cleared,
// both stages emptied, s_axis_tready held low
module xor_checked_frame_deframer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] rx_byte
    input  logic [xcfd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] command, [23:8] payload_length, [31:24] payload_byte
    output logic [xcfd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [1:0] event_kind
    output logic [xcfd_pkg::KIND_W-1:0]        m_axis_tuser
);
    import xcfd_pkg::*;

    // input stage
    logic                    r_in_valid;
    logic [RX_BYTE_W-1:0]    r_in_byte;

    // frame state
    logic [PHASE_W-1:0]      r_phase,     n_phase;
    logic [CMD_W-1:0]        r_command,   n_command;
    logic [LEN_W-1:0]        r_length,    n_length;
    logic [LEN_W-1:0]        r_left,      n_left;
    logic [RX_BYTE_W-1:0]    r_xor,       n_xor;

    // result stage
    logic                    r_out_valid, n_out_valid;
    logic [KIND_W-1:0]       r_kind,      n_kind;
    logic [CMD_W-1:0]        r_out_cmd,   n_out_cmd;
    logic [LEN_W-1:0]        r_out_len,   n_out_len;
    logic [RX_BYTE_W-1:0]    r_out_byte,  n_out_byte;

    logic                    advance;
    logic                    emit;
    logic [KIND_W-1:0]       emit_kind;
    logic [RX_BYTE_W-1:0]    emit_byte;
    logic [LEN_W-1:0]        left_dec;
    logic [LEN_W-1:0]        len_full;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = i_rst_n && (!r_in_valid || advance);

    assign left_dec = r_left - LEN_W'(1);
    assign len_full = {r_length[LEN_W-1:RX_BYTE_W], r_in_byte};

    always_comb begin
        n_phase   = r_phase;
        n_command = r_command;
        n_length  = r_length;
        n_left    = r_left;
        n_xor     = r_xor;
        emit      = 1'b0;
        emit_kind = EV_PAYLOAD;
        emit_byte = '0;
        case (r_phase)
            PH_HUNT_HI: begin
                if (r_in_byte == SYNC_A) n_phase = PH_HUNT_LO;
            end
            PH_HUNT_LO: begin
                if (r_in_byte == SYNC_B) n_phase = PH_CMD;
                else if (r_in_byte != SYNC_A) n_phase = PH_HUNT_HI;
            end
            PH_CMD: begin
                n_command = r_in_byte;
                n_xor     = r_in_byte;
                n_phase   = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_length = {r_in_byte, {RX_BYTE_W{1'b0}}};
                n_xor    = r_xor ^ r_in_byte;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_length = len_full;
                n_left   = len_full;
                n_xor    = r_xor ^ r_in_byte;
                n_phase  = (len_full == '0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_xor     = r_xor ^ r_in_byte;
                n_left    = left_dec;
                if (left_dec == '0) n_phase = PH_CHECK;
                emit      = 1'b1;
                emit_kind = EV_PAYLOAD;
                emit_byte = r_in_byte;
            end
            PH_CHECK: begin
                if (r_in_byte != r_xor) begin
                    n_phase   = PH_HUNT_HI;
                    emit      = 1'b1;
                    emit_kind = EV_CHECKSUM;
                end else begin
                    n_phase = PH_TAIL_HI;
                end
            end
            PH_TAIL_HI: begin
                if (r_in_byte != SYNC_B) begin
                    n_phase   = PH_HUNT_HI;
                    emit      = 1'b1;
                    emit_kind = EV_TAIL;
                end else begin
                    n_phase = PH_TAIL_LO;
                end
            end
            PH_TAIL_LO: begin
                n_phase   = PH_HUNT_HI;
                emit      = 1'b1;
                emit_kind = (r_in_byte == SYNC_A) ? EV_GOOD : EV_TAIL;
            end
            default: begin
                n_phase = PH_HUNT_HI;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_out_cmd   = r_out_cmd;
        n_out_len   = r_out_len;
        n_out_byte  = r_out_byte;
        if (advance) begin
            n_out_valid = emit;
            n_kind      = emit_kind;
            n_out_cmd   = n_command;
            n_out_len   = n_length;
            n_out_byte  = emit_byte;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_HUNT_HI;
            r_command   <= '0;
            r_length    <= '0;
            r_left      <= '0;
            r_xor       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_valid <= s_axis_tvalid;
            if (advance) begin
                r_phase   <= n_phase;
                r_command <= n_command;
                r_length  <= n_length;
                r_left    <= n_left;
                r_xor     <= n_xor;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tready) r_in_byte <= s_axis_tdata[RX_BYTE_W-1:0];
        r_kind     <= n_kind;
        r_out_cmd  <= n_out_cmd;
        r_out_len  <= n_out_len;
        r_out_byte <= n_out_byte;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_byte, r_out_len, r_out_cmd};
    assign m_axis_tuser  = r_kind;

endmodule

// File: verif/tb_xor_checked_frame_deframer.sv
// testbench for the xor checked frame deframer: byte-stream frames against a built-in predictor
`timescale 1ns / 100ps

module tb_xor_checked_frame_deframer;
    import xcfd_pkg::*;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_CHECKSUM,
        FRAME_BAD_TAIL_HI,
        FRAME_BAD_TAIL_LO,
        FRAME_CUT_SHORT
    } t_frame_shape;

    localparam int PHASE_ITEMS = 160;

    // tracks the parser state and the results each accepted byte should produce
    class t_deframer_scoreboard;
        typedef struct {
            logic [KIND_W-1:0]    kind;
            logic [CMD_W-1:0]     command;
            logic [LEN_W-1:0]     length;
            logic [RX_BYTE_W-1:0] payload;
        } t_frame_event;

        logic [PHASE_W-1:0]   phase;
        logic [CMD_W-1:0]     frame_cmd;
        logic [LEN_W-1:0]     frame_len;
        logic [LEN_W-1:0]     bytes_left;
        logic [RX_BYTE_W-1:0] xor_acc;
        t_frame_event         expected_events[$];
        int                   errors;
        int                   bytes_in;
        int                   kind_seen[4];

        function new();
            phase = PH_HUNT_HI;
            frame_cmd = '0;
            frame_len = '0;
            bytes_left = '0;
            xor_acc = '0;
            errors = 0;
            bytes_in = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        function void push_event(logic [KIND_W-1:0] kind, logic [RX_BYTE_W-1:0] data);
            t_frame_event ev;
            ev.kind = kind;
            ev.command = frame_cmd;
            ev.length = frame_len;
            ev.payload = data;
            expected_events.push_back(ev);
            kind_seen[kind]++;
        endfunction

        function void note_rx_byte(logic [RX_BYTE_W-1:0] b);
            bytes_in++;
            case (phase)
                PH_HUNT_HI: begin
                    if (b == SYNC_A) phase = PH_HUNT_LO;
                end
                PH_HUNT_LO: begin
                    // a second AA keeps waiting for 55
                    if (b == SYNC_B) phase = PH_CMD;
                    else if (b != SYNC_A) phase = PH_HUNT_HI;
                end
                PH_CMD: begin
                    frame_cmd = b;
                    xor_acc = b;
                    phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    frame_len = {b, 8'h00};
                    xor_acc = xor_acc ^ b;
                    phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    frame_len[7:0] = b;
                    xor_acc = xor_acc ^ b;
                    bytes_left = frame_len;
                    phase = (frame_len == '0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    xor_acc = xor_acc ^ b;
                    bytes_left = bytes_left - 1'b1;
                    if (bytes_left == '0) phase = PH_CHECK;
                    push_event(EV_PAYLOAD, b);
                end
                PH_CHECK: begin
                    if (b != xor_acc) begin
                        phase = PH_HUNT_HI;
                        push_event(EV_CHECKSUM, '0);
                    end else begin
                        phase = PH_TAIL_HI;
                    end
                end
                PH_TAIL_HI: begin
                    if (b != SYNC_B) begin
                        phase = PH_HUNT_HI;
                        push_event(EV_TAIL, '0);
                    end else begin
                        phase = PH_TAIL_LO;
                    end
                end
                PH_TAIL_LO: begin
                    phase = PH_HUNT_HI;
                    push_event((b == SYNC_A) ? EV_GOOD : EV_TAIL, '0);
                end
                default: begin
                    phase = PH_HUNT_HI;
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("ERROR @%0t: %s", $time, msg);
        endtask

        task check_result(logic [KIND_W-1:0] kind, logic [OUT_TDATA_W-1:0] tdata);
            t_frame_event want;
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction kind=%0d tdata=%h", kind, tdata));
                return;
            end
            want = expected_events.pop_front();
            if (kind !== want.kind)
                report_mismatch($sformatf("event_kind %0d, want %0d", kind, want.kind));
            if (tdata[7:0] !== want.command)
                report_mismatch($sformatf("command %h, want %h", tdata[7:0], want.command));
            if (tdata[23:8] !== want.length)
                report_mismatch($sformatf("payload_length %h, want %h",
                                          tdata[23:8], want.length));
            if (tdata[31:24] !== want.payload)
                report_mismatch($sformatf("payload_byte %h, want %h",
                                          tdata[31:24], want.payload));
        endtask
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [IN_TDATA_W-1:0]      s_axis_tdata;    // [7:0] rx_byte
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;    // [7:0] command, [23:8] length, [31:24] payload
    logic [KIND_W-1:0]          m_axis_tuser;    // [1:0] event_kind

    t_deframer_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int frame_bytes    = 0;

    xor_checked_frame_deframer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("xor_checked_frame_deframer: mismatch");
        $finish;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [RX_BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_rx_byte(b);
        @(negedge i_clk);
    endtask

    function automatic logic [RX_BYTE_W-1:0] any_byte_but(input logic [RX_BYTE_W-1:0] avoid);
        logic [RX_BYTE_W-1:0] b;
        do b = RX_BYTE_W'($urandom_range(255)); while (b == avoid);
        return b;
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 80) return LEN_W'($urandom_range(1, 8));
        if (r < 94) return LEN_W'($urandom_range(9, 40));
        if (r < 97) return LEN_W'($urandom_range(128, 255));
        return LEN_W'($urandom_range(256, 259));
    endfunction

    task automatic send_frame(input t_frame_shape shape, input logic [LEN_W-1:0] len);
        logic [CMD_W-1:0]     cmd;
        logic [RX_BYTE_W-1:0] chk;
        logic [RX_BYTE_W-1:0] b;
        int                   n_body;
        cmd = CMD_W'($urandom_range(255));
        chk = cmd ^ len[15:8] ^ len[7:0];
        // sometimes lead with a doubled first header byte
        if ($urandom_range(9) == 0) send_byte(SYNC_A);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(cmd);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        n_body = (shape == FRAME_CUT_SHORT) ? $urandom_range(0, int'(len) - 1) : int'(len);
        for (int i = 0; i < n_body; i++) begin
            b = RX_BYTE_W'($urandom_range(255));
            chk = chk ^ b;
            send_byte(b);
        end
        frame_bytes += 5 + n_body;
        // a cut-short frame leaves the parser in payload, later bytes fill it up
        if (shape == FRAME_CUT_SHORT) return;
        send_byte((shape == FRAME_BAD_CHECKSUM) ?
                  chk ^ RX_BYTE_W'($urandom_range(1, 255)) : chk);
        frame_bytes++;
        if (shape == FRAME_BAD_CHECKSUM) return;
        send_byte((shape == FRAME_BAD_TAIL_HI) ? any_byte_but(SYNC_B) : SYNC_B);
        frame_bytes++;
        if (shape == FRAME_BAD_TAIL_HI) return;
        send_byte((shape == FRAME_BAD_TAIL_LO) ? any_byte_but(SYNC_A) : SYNC_A);
        frame_bytes++;
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        // no 55 in noise, so no header forms by accident
        repeat (n) send_byte(any_byte_but(SYNC_B));
    endtask

    task automatic wait_drained();
        while (sb.expected_events.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        logic [RX_BYTE_W-1:0] directed_bytes[$];
        int                   send_idle_list[4];
        int                   recv_stall_list[4];
        int                   r;
        t_frame_shape         shape;
        logic [LEN_W-1:0]     len;

        send_idle_list  = '{0, 64, 0, 17};
        recv_stall_list = '{0, 0, 64, 17};
        // false start, doubled AA before a zero-length good frame, checksum error,
        // then a bad first tail byte
        directed_bytes = '{8'hAA, 8'h13,
                           8'hAA, 8'hAA, 8'h55, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h55, 8'hAA,
                           8'hAA, 8'h55, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00,
                           8'hAA, 8'h55, 8'h5A, 8'h00, 8'h00, 8'h5A, 8'h12};

        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
        // one frame with both length bytes nonzero
        send_frame(FRAME_GOOD, 16'h0102);
        s_axis_tvalid = 1'b0;
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_idle_list[p];
            recv_stall_pct = recv_stall_list[p];
            frame_bytes = 0;
            while (frame_bytes < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 10) begin
                    send_noise();
                end else begin
                    len = pick_length();
                    if (r < 60) shape = FRAME_GOOD;
                    else if (r < 72) shape = FRAME_BAD_CHECKSUM;
                    else if (r < 80) shape = FRAME_BAD_TAIL_HI;
                    else if (r < 88) shape = FRAME_BAD_TAIL_LO;
                    else shape = FRAME_CUT_SHORT;
                    if (shape == FRAME_CUT_SHORT && len == '0) len = 16'd1;
                    send_frame(shape, len);
                end
            end
            s_axis_tvalid = 1'b0;
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        $display("run: %0d bytes in over four flow-control phases, %0d payload transactions",
                 sb.bytes_in, sb.kind_seen[EV_PAYLOAD]);
        $display("frame ends: %0d good, %0d checksum errors, %0d tail errors",
                 sb.kind_seen[EV_GOOD], sb.kind_seen[EV_CHECKSUM], sb.kind_seen[EV_TAIL]);
        if (sb.errors == 0 && sb.expected_events.size() == 0)
            $display("xor_checked_frame_deframer: match");
        else
            $display("xor_checked_frame_deframer: mismatch");
        $finish;
    end

endmodule
